[src/i2c_mes_pkg.sv]
// ----------------------------------------------------------------------------
// i2c_mes_pkg
// Shared types, codes and ring helpers for the two-wire bus event sequencer.
// ----------------------------------------------------------------------------
package i2c_mes_pkg;

  localparam int unsigned TX_DEPTH = 16;
  localparam int unsigned RX_DEPTH = 16;
  localparam int unsigned TX_AW    = $clog2(TX_DEPTH);
  localparam int unsigned RX_AW    = $clog2(RX_DEPTH);

  localparam logic [7:0] HOLDOFF_RESET = 8'd250;
  localparam logic [7:0] STATUS_MASK   = 8'hF8;

  // Item kinds
  typedef enum logic [1:0] {
    MODE_ENQ    = 2'd0,
    MODE_STATUS = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_POP    = 2'd3
  } mode_e;

  // Control actions returned with each result
  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_SEND       = 3'd1,
    ACT_ACK        = 3'd2,
    ACT_STOP       = 3'd3,
    ACT_RECOVER    = 3'd4,
    ACT_START      = 3'd5,
    ACT_START_STOP = 3'd6
  } action_e;

  // Configuration register indexes
  localparam logic CFG_GC_BIT  = 1'b0;
  localparam logic CFG_HOLDOFF = 1'b1;

  // Bus controller status codes, low three bits masked
  localparam logic [7:0] ST_BUS_ERR   = 8'h00;
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_RSTART    = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK = 8'h20;
  localparam logic [7:0] ST_TXD_ACK   = 8'h28;
  localparam logic [7:0] ST_TXD_NACK  = 8'h30;
  localparam logic [7:0] ST_ARB_LOST  = 8'h38;
  localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK = 8'h48;
  localparam logic [7:0] ST_RXD_LAST  = 8'h50;
  localparam logic [7:0] ST_RXD_NACK  = 8'h58;
  localparam logic [7:0] ST_SR_SLA    = 8'h60;
  localparam logic [7:0] ST_SR_ARB    = 8'h68;
  localparam logic [7:0] ST_SR_GC     = 8'h70;
  localparam logic [7:0] ST_SR_GCARB  = 8'h78;
  localparam logic [7:0] ST_SR_DATA   = 8'h80;
  localparam logic [7:0] ST_SR_DLAST  = 8'h88;
  localparam logic [7:0] ST_SR_GDATA  = 8'h90;
  localparam logic [7:0] ST_SR_GLAST  = 8'h98;
  localparam logic [7:0] ST_SR_STOP   = 8'hA0;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  typedef struct packed {
    logic load;  // take the input transfer into the item register
    logic exec;  // execute the held item and load the result register
  } cmd_t;

  typedef struct packed {
    logic out_free;  // result register empty or being taken
  } status_t;

  function automatic logic [TX_AW-1:0] tx_next(input logic [TX_AW-1:0] i);
    tx_next = (i == TX_AW'(TX_DEPTH - 1)) ? '0 : i + TX_AW'(1);
  endfunction

  function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] i);
    rx_next = (i == RX_AW'(RX_DEPTH - 1)) ? '0 : i + RX_AW'(1);
  endfunction

endpackage

[src/i2c_mes_ctrl.sv]
// ----------------------------------------------------------------------------
// i2c_mes_ctrl
// Item sequencing: take an item, then execute it once the result slot is free.
// ----------------------------------------------------------------------------
module i2c_mes_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  i2c_mes_pkg::status_t  status_i,
  output i2c_mes_pkg::cmd_t     cmd_o
);

  i2c_mes_pkg::state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o.load  = 1'b0;
    cmd_o.exec  = 1'b0;
    case (state_q)
      i2c_mes_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = i2c_mes_pkg::ST_EXEC;
        end
      end
      i2c_mes_pkg::ST_EXEC: begin
        if (status_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = i2c_mes_pkg::ST_IDLE;
        end
      end
      default: state_d = i2c_mes_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2c_mes_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/i2c_mes_dp.sv]
// ----------------------------------------------------------------------------
// i2c_mes_dp
// Rings, sequencer state, status decode and the result register.
// ----------------------------------------------------------------------------
module i2c_mes_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  i2c_mes_pkg::cmd_t    cmd_i,
  output i2c_mes_pkg::status_t status_o,
  input  logic [31:0]          in_data_i,
  input  logic [1:0]           in_user_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [23:0]          out_data_o
);

  localparam int unsigned TAW = i2c_mes_pkg::TX_AW;
  localparam int unsigned RAW = i2c_mes_pkg::RX_AW;

  // Item register
  logic [1:0] mode_q;
  logic [6:0] addr_q;
  logic [7:0] wbyte_q, st_q, bdata_q;

  // Configuration
  logic       gc_bit_q;
  logic [7:0] holdoff_cfg_q;

  // Stores
  logic [6:0] tx_addr_mem [i2c_mes_pkg::TX_DEPTH];
  logic [7:0] tx_data_mem [i2c_mes_pkg::TX_DEPTH];
  logic [7:0] rx_mem      [i2c_mes_pkg::RX_DEPTH];

  logic [TAW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [RAW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [6:0]     latched_q, latched_d;
  logic           busy_q, busy_d;
  logic [7:0]     holdoff_q, holdoff_d;

  logic           out_valid_q;
  logic [23:0]    out_data_q;

  // Execute-cycle signals
  logic [TAW-1:0]        tx_t, tx_h;
  logic [RAW-1:0]        rx_t;
  logic                  tx_ne;
  logic                  tx_we, rx_we;
  logic [7:0]            st_m;
  i2c_mes_pkg::action_e  act;
  logic [7:0]            txb, rxb;
  logic                  rxv, drop;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    tx_t      = i2c_mes_pkg::tx_next(tx_tail_q);
    tx_h      = i2c_mes_pkg::tx_next(tx_head_q);
    rx_t      = i2c_mes_pkg::rx_next(rx_tail_q);
    tx_ne     = (tx_head_q != tx_tail_q);
    st_m      = st_q & i2c_mes_pkg::STATUS_MASK;
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    latched_d = latched_q;
    busy_d    = busy_q;
    holdoff_d = holdoff_q;
    tx_we     = 1'b0;
    rx_we     = 1'b0;
    act       = i2c_mes_pkg::ACT_NONE;
    txb       = 8'd0;
    rxb       = 8'd0;
    rxv       = 1'b0;
    drop      = 1'b0;

    case (i2c_mes_pkg::mode_e'(mode_q))
      i2c_mes_pkg::MODE_ENQ: begin
        if (tx_h != tx_tail_q) begin
          tx_we     = 1'b1;
          tx_head_d = tx_h;
        end else begin
          drop = 1'b1;
        end
      end
      i2c_mes_pkg::MODE_STATUS: begin
        busy_d = 1'b1;
        case (st_m)
          i2c_mes_pkg::ST_START, i2c_mes_pkg::ST_RSTART: begin
            if (tx_ne) begin
              latched_d = tx_addr_mem[tx_t];
              txb       = {tx_addr_mem[tx_t], 1'b0} + {7'd0, gc_bit_q};
              act       = i2c_mes_pkg::ACT_SEND;
            end else begin
              busy_d = 1'b0;
              act    = i2c_mes_pkg::ACT_STOP;
            end
          end
          i2c_mes_pkg::ST_SLAW_ACK, i2c_mes_pkg::ST_TXD_ACK: begin
            // data follows only while the queued pair targets the latched address
            if (tx_ne && (tx_addr_mem[tx_t] == latched_q)) begin
              tx_tail_d = tx_t;
              txb       = tx_data_mem[tx_t];
              act       = i2c_mes_pkg::ACT_SEND;
            end else begin
              busy_d = 1'b0;
              act    = i2c_mes_pkg::ACT_STOP;
            end
          end
          i2c_mes_pkg::ST_TXD_NACK, i2c_mes_pkg::ST_RXD_NACK,
          i2c_mes_pkg::ST_BUS_ERR: begin
            busy_d = 1'b0;
            act    = i2c_mes_pkg::ACT_STOP;
          end
          i2c_mes_pkg::ST_SLAR_ACK, i2c_mes_pkg::ST_SR_SLA, i2c_mes_pkg::ST_SR_ARB,
          i2c_mes_pkg::ST_SR_GC, i2c_mes_pkg::ST_SR_GCARB: begin
            act = i2c_mes_pkg::ACT_ACK;
          end
          i2c_mes_pkg::ST_SLAR_NACK: begin
            busy_d = 1'b0;
            act    = i2c_mes_pkg::ACT_START_STOP;
          end
          i2c_mes_pkg::ST_SR_DATA, i2c_mes_pkg::ST_SR_GDATA: begin
            rx_we     = 1'b1;
            rx_head_d = i2c_mes_pkg::rx_next(rx_head_q);
            act       = i2c_mes_pkg::ACT_ACK;
          end
          i2c_mes_pkg::ST_RXD_LAST, i2c_mes_pkg::ST_SR_DLAST,
          i2c_mes_pkg::ST_SR_GLAST: begin
            rx_we     = 1'b1;
            rx_head_d = i2c_mes_pkg::rx_next(rx_head_q);
            busy_d    = 1'b0;
            act       = i2c_mes_pkg::ACT_ACK;
          end
          i2c_mes_pkg::ST_SR_STOP: begin
            busy_d = 1'b0;
            act    = i2c_mes_pkg::ACT_ACK;
          end
          default: begin
            // NACK after write address, arbitration loss and unknown codes
            holdoff_d = holdoff_cfg_q;
            busy_d    = 1'b0;
            act       = i2c_mes_pkg::ACT_RECOVER;
          end
        endcase
      end
      i2c_mes_pkg::MODE_TICK: begin
        if (holdoff_q == 8'd0) begin
          if (!busy_q && tx_ne) act = i2c_mes_pkg::ACT_START;
        end else if (holdoff_q == 8'd1) begin
          act       = i2c_mes_pkg::ACT_START_STOP;
          holdoff_d = 8'd0;
        end else begin
          holdoff_d = holdoff_q - 8'd1;
        end
      end
      i2c_mes_pkg::MODE_POP: begin
        if (rx_head_q != rx_tail_q) begin
          rx_tail_d = rx_t;
          rxb       = rx_mem[rx_t];
          rxv       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Item register, stores: no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q  <= in_data_i[6:0];
      wbyte_q <= in_data_i[14:7];
      st_q    <= in_data_i[22:15];
      bdata_q <= in_data_i[30:23];
      mode_q  <= in_user_i;
    end
    if (cmd_i.exec && tx_we) begin
      tx_addr_mem[tx_h] <= addr_q;
      tx_data_mem[tx_h] <= wbyte_q;
    end
    if (cmd_i.exec && rx_we) begin
      rx_mem[rx_head_d] <= bdata_q;
    end
    if (cmd_i.exec) begin
      out_data_q <= {2'b00, drop, busy_d, rxb, rxv, txb, act};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gc_bit_q      <= 1'b0;
      holdoff_cfg_q <= i2c_mes_pkg::HOLDOFF_RESET;
      tx_head_q     <= '0;
      tx_tail_q     <= '0;
      rx_head_q     <= '0;
      rx_tail_q     <= '0;
      latched_q     <= 7'd0;
      busy_q        <= 1'b0;
      holdoff_q     <= 8'd0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          i2c_mes_pkg::CFG_GC_BIT:  gc_bit_q      <= cfg_data_i[0];
          i2c_mes_pkg::CFG_HOLDOFF: holdoff_cfg_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.exec) begin
        tx_head_q <= tx_head_d;
        tx_tail_q <= tx_tail_d;
        rx_head_q <= rx_head_d;
        rx_tail_q <= rx_tail_d;
        latched_q <= latched_d;
        busy_q    <= busy_d;
        holdoff_q <= holdoff_d;
      end
      if (cmd_i.exec) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[src/i2c_master_event_sequencer_core.sv]
// ----------------------------------------------------------------------------
// i2c_master_event_sequencer_core
// Two-wire bus master event sequencer: transmit and receive rings, status
// decode to control actions and error hold-off.
// ----------------------------------------------------------------------------
// The controller takes each item into the item register in the idle state and
// executes it against the ring and sequencer state in a single update in the
// execute state. The execute step waits while the previous result still sits
// unread in the result register; no new item is taken until the current one has
// executed. Exactly one result is returned per item. Configuration writes are
// taken at any time and must only be issued while the block is idle.
module i2c_master_event_sequencer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [6:0] slave_addr, [14:7] write_byte, [22:15] bus_status, [30:23] bus_data
  input  logic [31:0] s_axis_tdata,
  // [1:0] mode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] action, [10:3] tx_byte, [11] rx_valid, [19:12] rx_byte,
  // [20] busy_res, [21] dropped
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  i2c_mes_pkg::cmd_t    cmd;
  i2c_mes_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  i2c_mes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  i2c_mes_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // An accepted item is executed before the next one is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item taken while another is pending");

  // Execution never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten");

  // A dropped enqueue or a popped byte never comes with a bus action
  a_quiet_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[21] || m_axis_tdata[11]))
      |-> (m_axis_tdata[2:0] == i2c_mes_pkg::ACT_NONE))
    else $error("action reported with enqueue or pop result");

endmodule

[sim/i2c_mes_checker.sv]
// ----------------------------------------------------------------------------
// i2c_mes_checker
// Watches the item, reply and register channels of the event sequencer, keeps
// its own copy of the rings and sequencer state, and compares every reply
// with the one worked out when the item was taken.
// ----------------------------------------------------------------------------
module i2c_mes_checker
  import i2c_mes_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // [6:0] slave_addr, [14:7] write_byte, [22:15] bus_status, [30:23] bus_data
  input  logic [31:0] s_axis_tdata,
  // [1:0] mode
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] action, [10:3] tx_byte, [11] rx_valid, [19:12] rx_byte,
  // [20] busy_res, [21] dropped
  input  logic [23:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output int          fail_count_o,
  output int          outstanding_o,
  output int          compared_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    action_e    action;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       busy;
    logic       dropped;
  } bus_reply_t;

  // sequencer state as seen from outside
  logic [6:0]       q_addr [TX_DEPTH];
  logic [7:0]       q_data [TX_DEPTH];
  logic [TX_AW-1:0] q_head, q_tail;
  logic [7:0]       rx_mem [RX_DEPTH];
  logic [RX_AW-1:0] rx_wr, rx_rd;
  logic [6:0]       cur_addr;
  logic             busy;
  logic [7:0]       backoff;
  logic             gc_bit;
  logic [7:0]       backoff_load;

  bus_reply_t bus_replies [$];
  bus_reply_t want, got;
  int         fails;
  int         compared;

  assign fail_count_o = fails;
  assign compared_o   = compared;

  function automatic logic [TX_AW-1:0] tx_advance(input logic [TX_AW-1:0] i);
    return TX_AW'((int'(i) + 1) % TX_DEPTH);
  endfunction

  function automatic logic [RX_AW-1:0] rx_advance(input logic [RX_AW-1:0] i);
    return RX_AW'((int'(i) + 1) % RX_DEPTH);
  endfunction

  function automatic bus_reply_t decode_item(input mode_e m, input logic [6:0] addr,
                                             input logic [7:0] wb, input logic [7:0] st,
                                             input logic [7:0] bd);
    bus_reply_t       r;
    logic [TX_AW-1:0] nxt;
    r = '0;
    case (m)
      MODE_ENQ: begin
        nxt = tx_advance(q_head);
        if (nxt != q_tail) begin
          q_addr[nxt] = addr;
          q_data[nxt] = wb;
          q_head      = nxt;
        end else begin
          r.dropped = 1'b1;
        end
      end
      MODE_STATUS: begin
        busy = 1'b1;
        nxt  = tx_advance(q_tail);
        case (st & STATUS_MASK)
          ST_START, ST_RSTART: begin
            if (q_head != q_tail) begin
              cur_addr  = q_addr[nxt];
              r.tx_byte = {cur_addr, 1'b0} + 8'(gc_bit);
              r.action  = ACT_SEND;
            end else begin
              busy     = 1'b0;
              r.action = ACT_STOP;
            end
          end
          ST_SLAW_ACK, ST_TXD_ACK: begin
            // data only flows while the oldest queued entry still targets the latched address
            if (q_head != q_tail && q_addr[nxt] == cur_addr) begin
              q_tail    = nxt;
              r.tx_byte = q_data[nxt];
              r.action  = ACT_SEND;
            end else begin
              busy     = 1'b0;
              r.action = ACT_STOP;
            end
          end
          ST_TXD_NACK, ST_RXD_NACK, ST_BUS_ERR: begin
            busy     = 1'b0;
            r.action = ACT_STOP;
          end
          ST_SLAR_ACK, ST_SR_SLA, ST_SR_ARB, ST_SR_GC, ST_SR_GCARB: r.action = ACT_ACK;
          ST_SLAR_NACK: begin
            busy     = 1'b0;
            r.action = ACT_START_STOP;
          end
          ST_SR_DATA, ST_SR_GDATA: begin
            rx_wr         = rx_advance(rx_wr);
            rx_mem[rx_wr] = bd;
            r.action      = ACT_ACK;
          end
          ST_RXD_LAST, ST_SR_DLAST, ST_SR_GLAST: begin
            rx_wr         = rx_advance(rx_wr);
            rx_mem[rx_wr] = bd;
            busy          = 1'b0;
            r.action      = ACT_ACK;
          end
          ST_SR_STOP: begin
            busy     = 1'b0;
            r.action = ACT_ACK;
          end
          default: begin
            // write-address nack, arbitration loss and anything unknown
            backoff  = backoff_load;
            busy     = 1'b0;
            r.action = ACT_RECOVER;
          end
        endcase
      end
      MODE_TICK: begin
        if (backoff == 8'd0) begin
          if (!busy && q_head != q_tail) r.action = ACT_START;
        end else if (backoff == 8'd1) begin
          r.action = ACT_START_STOP;
          backoff  = 8'd0;
        end else begin
          backoff = backoff - 8'd1;
        end
      end
      default: begin
        if (rx_wr != rx_rd) begin
          rx_rd      = rx_advance(rx_rd);
          r.rx_byte  = rx_mem[rx_rd];
          r.rx_valid = 1'b1;
        end
      end
    endcase
    r.busy = busy;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("reply field %s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TX_DEPTH; i++) begin
        q_addr[i] = '0;
        q_data[i] = '0;
      end
      for (int i = 0; i < RX_DEPTH; i++) rx_mem[i] = '0;
      q_head        = '0;
      q_tail        = '0;
      rx_wr         = '0;
      rx_rd         = '0;
      cur_addr      = '0;
      busy          = 1'b0;
      backoff       = '0;
      gc_bit        = 1'b0;
      backoff_load  = HOLDOFF_RESET;
      fails         = 0;
      compared      = 0;
      bus_replies.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_GC_BIT:  gc_bit       = cfg_data_i[0];
          CFG_HOLDOFF: backoff_load = cfg_data_i;
          default: ;
        endcase
      end
      // replies always leave after their item was taken, so compare first
      if (m_axis_tvalid && m_axis_tready) begin
        if (bus_replies.size() == 0) begin
          $error("reply %h with nothing awaited", m_axis_tdata);
          fails++;
        end else begin
          want = bus_replies.pop_front();
          got  = {action_e'(m_axis_tdata[2:0]), m_axis_tdata[10:3], m_axis_tdata[11],
                  m_axis_tdata[19:12], m_axis_tdata[20], m_axis_tdata[21]};
          check_field("action", 8'(want.action), 8'(m_axis_tdata[2:0]));
          check_field("tx_byte", want.tx_byte, got.tx_byte);
          check_field("rx_valid", 8'(want.rx_valid), 8'(m_axis_tdata[11]));
          check_field("rx_byte", want.rx_byte, got.rx_byte);
          check_field("busy_res", 8'(want.busy), 8'(m_axis_tdata[20]));
          check_field("dropped", 8'(want.dropped), 8'(m_axis_tdata[21]));
          compared++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        bus_replies.push_back(decode_item(mode_e'(s_axis_tuser), s_axis_tdata[6:0],
                                          s_axis_tdata[14:7], s_axis_tdata[22:15],
                                          s_axis_tdata[30:23]));
      end
      outstanding_o <= bus_replies.size();
    end
  end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the event sequencer with enqueue, status, tick and pop items: a short
// directed opening, then write and read transfers, ring fill and overrun
// bursts and random noise under several register settings, with random gaps
// on both streams and one long output stall.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import i2c_mes_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 300;
  localparam int STALL_CYCLES   = 250;

  localparam logic [7:0] KNOWN_CODES [21] = '{
    ST_BUS_ERR, ST_START, ST_RSTART, ST_SLAW_ACK, ST_SLAW_NACK, ST_TXD_ACK, ST_TXD_NACK,
    ST_ARB_LOST, ST_SLAR_ACK, ST_SLAR_NACK, ST_RXD_LAST, ST_RXD_NACK, ST_SR_SLA,
    ST_SR_ARB, ST_SR_GC, ST_SR_GCARB, ST_SR_DATA, ST_SR_DLAST, ST_SR_GDATA, ST_SR_GLAST,
    ST_SR_STOP
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [7:0]  cfg_data_i;

  int fail_count;
  int outstanding;
  int compared;
  int items_sent;
  int quiet_cycles = 0;
  int hold_requests;
  bit gaps_on;

  i2c_master_event_sequencer_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  i2c_mes_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .compared_o    (compared)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // reply side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    int served;
    hold_left     = 0;
    served        = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (served != hold_requests) begin
        served    = hold_requests;
        hold_left = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(99) < 31) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: timeout, no transfer for %0d cycles", quiet_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] noisy(input logic [7:0] code);
    return code | 8'($urandom_range(7));
  endfunction

  function automatic int pick_addr();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 127 : 0;
    return $urandom_range(127);
  endfunction

  // negative field values are filled at random
  task automatic push_item(input mode_e m, input int addr = -1, input int wb = -1,
                           input int st = -1, input int bd = -1);
    logic [6:0] a;
    logic [7:0] w, s, d;
    a = (addr < 0) ? 7'($urandom) : 7'(addr);
    w = (wb < 0) ? 8'($urandom) : 8'(wb);
    s = (st < 0) ? 8'($urandom) : 8'(st);
    d = (bd < 0) ? 8'($urandom) : 8'(bd);
    if (gaps_on) begin
      while ($urandom_range(99) < 31) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= m;
    s_axis_tdata  <= {1'b0, d, s, w, a};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic cfg_write(input logic idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic run_traffic(input int n_items);
    int first;
    int pick;
    int k;
    int a;
    first = items_sent;
    while (items_sent - first < n_items) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        // write transfer to one address, sometimes with a stray pair behind it
        k = $urandom_range(1, 4);
        a = pick_addr();
        for (int i = 0; i < k; i++) push_item(MODE_ENQ, a);
        if ($urandom_range(3) == 0) push_item(MODE_ENQ, pick_addr());
        push_item(MODE_TICK);
        push_item(MODE_STATUS, -1, -1, noisy($urandom_range(1) ? ST_START : ST_RSTART));
        for (int i = 0; i <= k; i++) begin
          case ($urandom_range(19))
            0:       push_item(MODE_STATUS, -1, -1, noisy(ST_SLAW_NACK));
            1:       push_item(MODE_STATUS, -1, -1, noisy(ST_TXD_NACK));
            2:       push_item(MODE_STATUS, -1, -1, noisy(ST_ARB_LOST));
            default: push_item(MODE_STATUS, -1, -1,
                               noisy((i == 0) ? ST_SLAW_ACK : ST_TXD_ACK));
          endcase
        end
      end else if (pick < 60) begin
        // read transfer, then collect the bytes
        k = $urandom_range(0, 5);
        push_item(MODE_STATUS, -1, -1, noisy(ST_START));
        push_item(MODE_STATUS, -1, -1,
                  noisy(($urandom_range(9) == 0) ? ST_SLAR_NACK : ST_SLAR_ACK));
        for (int i = 0; i < k; i++)
          push_item(MODE_STATUS, -1, -1, noisy($urandom_range(1) ? ST_SR_DATA : ST_SR_GDATA));
        case ($urandom_range(2))
          0:       push_item(MODE_STATUS, -1, -1, noisy(ST_RXD_LAST));
          1:       push_item(MODE_STATUS, -1, -1, noisy(ST_SR_DLAST));
          default: push_item(MODE_STATUS, -1, -1, noisy(ST_SR_GLAST));
        endcase
        for (int i = 0; i < k + 2; i++) push_item(MODE_POP);
      end else if (pick < 70) begin
        k = $urandom_range(1, 40);
        for (int i = 0; i < k; i++) push_item(MODE_TICK);
      end else if (pick < 75) begin
        // fill the transmit ring past full, then drain it
        a = pick_addr();
        for (int i = 0; i < TX_DEPTH + 1; i++) push_item(MODE_ENQ, a);
        push_item(MODE_STATUS, -1, -1, noisy(ST_START));
        for (int i = 0; i < TX_DEPTH; i++) push_item(MODE_STATUS, -1, -1, noisy(ST_TXD_ACK));
      end else if (pick < 78) begin
        // receive ring overrun: head laps the tail
        k = $urandom_range(RX_DEPTH + 1, RX_DEPTH + 4);
        for (int i = 0; i < k; i++) push_item(MODE_STATUS, -1, -1, noisy(ST_SR_DATA));
        for (int i = 0; i < 4; i++) push_item(MODE_POP);
      end else if (pick < 89) begin
        push_item(MODE_STATUS, -1, -1, noisy(KNOWN_CODES[$urandom_range(20)]));
      end else begin
        push_item(mode_e'($urandom_range(3)));
      end
    end
  endtask

  initial begin
    logic       gc_set   [PHASES];
    logic [7:0] hold_set [PHASES];
    gc_set   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    hold_set = '{HOLDOFF_RESET, 8'd2, 8'd255, 8'd0, 8'd1, 8'($urandom_range(2, 40))};
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = 1'b0;
    cfg_data_i    = '0;
    items_sent    = 0;
    hold_requests = 0;
    gaps_on       = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed opening under reset settings
    push_item(MODE_POP);                                   // empty receive ring
    push_item(MODE_TICK);                                  // idle, nothing queued
    push_item(MODE_STATUS, -1, -1, ST_START);              // start with an empty queue
    push_item(MODE_ENQ, 127, 255);
    push_item(MODE_ENQ, 127, 0);
    push_item(MODE_ENQ, 0, 8'h55);
    push_item(MODE_TICK);
    push_item(MODE_STATUS, -1, -1, ST_START | 8'h07);      // low bits ignored
    push_item(MODE_STATUS, -1, -1, ST_SLAW_ACK);
    push_item(MODE_STATUS, -1, -1, ST_TXD_ACK);
    push_item(MODE_STATUS, -1, -1, ST_TXD_ACK);            // next pair for another address
    push_item(MODE_STATUS, -1, -1, ST_RSTART);
    push_item(MODE_STATUS, -1, -1, ST_SLAW_ACK);
    push_item(MODE_STATUS, -1, -1, ST_TXD_ACK);            // queue now empty
    push_item(MODE_STATUS, -1, -1, ST_SLAR_ACK);
    push_item(MODE_STATUS, -1, -1, ST_SR_DATA, 255);
    push_item(MODE_STATUS, -1, -1, ST_RXD_LAST, 0);
    push_item(MODE_STATUS, -1, -1, ST_SLAR_NACK);
    push_item(MODE_POP);
    push_item(MODE_POP);
    push_item(MODE_POP);
    push_item(MODE_STATUS, -1, -1, ST_SR_STOP);
    push_item(MODE_STATUS, -1, -1, 8'hF8);                 // unknown code
    push_item(MODE_TICK);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      cfg_write(CFG_GC_BIT, 8'(gc_set[p]));
      cfg_write(CFG_HOLDOFF, hold_set[p]);
      cfg_valid_i <= 1'b0;
      gaps_on = (p != 2);
      if (p == 1) hold_requests++;
      run_traffic(PHASE_ITEMS);
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("tb: %0d items over %0d register settings, %0d replies compared",
             items_sent, PHASES, compared);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[i2c_master_event_sequencer_core.f]
src/i2c_mes_pkg.sv
src/i2c_mes_ctrl.sv
src/i2c_mes_dp.sv
src/i2c_master_event_sequencer_core.sv
sim/i2c_mes_checker.sv
sim/testbench.sv
